[hw/rtl/gstp_pkg.sv]
package gstp_pkg;

  localparam int ROW_LEN_DEF = 64;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 31;
  localparam int ACC_W       = 64;
  localparam int CAP_W       = 41;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;
  localparam logic [CAP_W-1:0] TERM_CAP  = 41'h100_0000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] eta_value;
    logic                     last_in_row;
    logic                     mode;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_value;
    logic                     last_out;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] num_hi;
    logic [ACC_W-1:0] num_lo;
    logic [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quo;
  } div_rsp_t;

endpackage

[hw/rtl/gstp_div.sv]
module gstp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gstp_pkg::div_req_t req_i,
  output gstp_pkg::div_rsp_t rsp_o
);
  import gstp_pkg::*;

  localparam int CW = $clog2(ACC_W);

  logic             run_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [ACC_W-1:0] rem_q;
  logic [ACC_W-1:0] lo_q;
  logic [ACC_W-1:0] den_q;
  logic [ACC_W-1:0] quo_q;
  logic [ACC_W-1:0] shifted;
  logic             take;
  logic             sat;

  assign shifted = {rem_q[ACC_W-2:0], lo_q[ACC_W-1]};
  assign take    = rem_q[ACC_W-1] || (shifted >= den_q);
  assign sat     = req_i.num_hi >= req_i.den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q  <= !sat;
        done_q <= sat;
        cnt_q  <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ACC_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num_hi;
      lo_q  <= req_i.num_lo;
      den_q <= req_i.den;
      quo_q <= sat ? '1 : '0;
    end else if (run_q) begin
      rem_q <= take ? shifted - den_q : shifted;
      lo_q  <= {lo_q[ACC_W-2:0], 1'b0};
      quo_q <= {quo_q[ACC_W-2:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[hw/rtl/group_soft_threshold_prox.sv]
// Row-wise group soft thresholding. Elements load at one per cycle while busy
// is low; the element that ends a row raises busy. The row then runs the
// bit-serial square root and scaling, then the shrink factor division when
// the row norm clears the threshold, and then works through its elements in
// turn; in mode 1 each element of a row that clears the threshold runs the
// shared 64-step divider. Results leave one per strobe cycle and cannot be
// stalled; busy falls in the cycle that the last result of the row is shown,
// and the next element may then be started.
module group_soft_threshold_prox #(
  parameter int ROW_LEN = gstp_pkg::ROW_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  gstp_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  output gstp_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [gstp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gstp_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import gstp_pkg::*;

  localparam int AW = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int CW = $clog2(ROW_LEN + 1);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_DRN  = 4'd1;
  localparam logic [3:0] ST_SQI  = 4'd2;
  localparam logic [3:0] ST_SQRT = 4'd3;
  localparam logic [3:0] ST_SMUL = 4'd4;
  localparam logic [3:0] ST_DST  = 4'd5;
  localparam logic [3:0] ST_DWT  = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_MUL1 = 4'd8;
  localparam logic [3:0] ST_MUL2 = 4'd9;
  localparam logic [3:0] ST_DIVS = 4'd10;
  localparam logic [3:0] ST_DIVW = 4'd11;
  localparam logic [3:0] ST_EM1  = 4'd12;
  localparam logic [3:0] ST_EM2  = 4'd13;
  localparam logic [3:0] ST_EM3  = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  logic [2*DATA_W-1:0] mem [ROW_LEN];
  logic [2*DATA_W-1:0] rd_q;

  logic [3:0]        state_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     n_q;
  logic [CW-1:0]     k_q;
  logic              mode_q;
  logic              pvalid_q;
  logic              clr;
  logic [ACC_W-1:0]  sqp_q;
  logic signed [ACC_W-1:0] dp_q;
  logic [ACC_W-1:0]  ss_q;
  logic signed [ACC_W-1:0] dot_q;
  logic [CFG_W-1:0]  lam_q;
  logic [CFG_W-1:0]  w_q;
  logic [ACC_W-1:0]  sq_val_q;
  logic [34:0]       sq_rem_q;
  logic [31:0]       root_q;
  logic [4:0]        it_q;
  logic [62:0]       s_q;
  logic              active_q;
  logic [ACC_W-1:0]  dmag_q;
  logic              dneg_q;
  logic [31:0]       d_q;
  logic [63:0]       t1p_q;
  logic [63:0]       p0_q;
  logic [63:0]       p1_q;
  logic [31:0]       t1_q;
  logic [ACC_W-1:0]  quo_q;
  logic [64:0]       eql_q;
  logic [64:0]       eqh_q;
  logic [CAP_W-1:0]  t2_q;
  out_item_t         out_q;
  logic              out_valid_q;

  logic              accept;
  logic              row_end;
  logic [31:0]       xm_in;
  logic [64:0]       ss_sum;
  logic signed [64:0] dot_sum;
  logic [34:0]       sq_r2;
  logic [34:0]       sq_trial;
  logic [46:0]       lam_s;
  logic              active_d;
  logic [62:0]       sdiff;
  logic [95:0]       full_num;
  logic signed [DATA_W-1:0] xr;
  logic signed [DATA_W-1:0] er;
  logic signed [DATA_W-1:0] vr;
  logic [31:0]       xm;
  logic [31:0]       vm;
  logic [63:0]       t1_rnd;
  logic [32:0]       e_val;
  logic [96:0]       eq_sum;
  logic [64:0]       eq_r;
  logic signed [42:0] t1s;
  logic signed [42:0] t2s;
  logic signed [42:0] ysum;
  logic signed [DATA_W-1:0] ysat;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign accept  = start && !busy;
  assign row_end = in_item_i.last_in_row || (cnt_q == CW'(ROW_LEN - 1));
  assign xm_in   = in_item_i.x_value[DATA_W-1] ? 32'(-in_item_i.x_value)
                                               : 32'(in_item_i.x_value);
  assign clr     = (state_q == ST_OUT) && (k_q + 1'b1 == n_q);

  assign ss_sum  = {1'b0, ss_q} + {1'b0, sqp_q};
  assign dot_sum = {dot_q[ACC_W-1], dot_q} + {dp_q[ACC_W-1], dp_q};

  assign sq_r2    = {sq_rem_q[32:0], sq_val_q[ACC_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign lam_s    = {lam_q, 16'b0};
  assign active_d = s_q > {16'b0, lam_s};
  assign sdiff    = s_q - {16'b0, lam_s};
  assign full_num = {32'b0, p0_q} + {p1_q, 32'b0};

  assign xr    = rd_q[DATA_W-1:0];
  assign er    = rd_q[2*DATA_W-1:DATA_W];
  assign vr    = mode_q ? er : xr;
  assign xm    = xr[DATA_W-1] ? 32'(-xr) : 32'(xr);
  assign vm    = vr[DATA_W-1] ? 32'(-vr) : 32'(vr);
  assign t1_rnd = t1p_q + 64'h8000_0000;
  assign e_val  = 33'h1_0000_0000 - {1'b0, d_q};
  assign eq_sum = {32'b0, eql_q} + {eqh_q, 32'b0} + 97'h8000_0000;
  assign eq_r   = eq_sum[96:32];

  assign t1s  = vr[DATA_W-1] ? -$signed({11'b0, t1_q}) : $signed({11'b0, t1_q});
  assign t2s  = (dneg_q ^ xr[DATA_W-1]) ? -$signed({2'b0, t2_q}) : $signed({2'b0, t2_q});
  assign ysum = t1s + t2s;
  always_comb begin
    if (ysum > 43'sd2147483647) begin
      ysat = 32'sh7FFF_FFFF;
    end else if (ysum < -43'sd2147483648) begin
      ysat = 32'sh8000_0000;
    end else begin
      ysat = ysum[DATA_W-1:0];
    end
  end

  always_comb begin
    div_req.start  = ((state_q == ST_DST) && active_d) || (state_q == ST_DIVS);
    div_req.num_hi = {33'b0, sdiff[62:32]};
    div_req.num_lo = {sdiff[31:0], 32'b0};
    div_req.den    = {1'b0, s_q};
    if (state_q == ST_DIVS) begin
      div_req.num_hi = {32'b0, full_num[95:64]};
      div_req.num_lo = full_num[63:0];
      div_req.den    = ss_q;
    end
  end

  gstp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[cnt_q[AW-1:0]] <= {in_item_i.eta_value, in_item_i.x_value};
    end
    rd_q <= mem[k_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q <= CFG_RESET;
      w_q   <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LAMBDA: lam_q <= cfg_wdata_i;
        CFG_WEIGHT: w_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q  <= '0;
      dot_q <= '0;
    end else if (clr) begin
      ss_q  <= '0;
      dot_q <= '0;
    end else if (pvalid_q) begin
      ss_q <= ss_sum[ACC_W] ? '1 : ss_sum[ACC_W-1:0];
      if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
        dot_q <= dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        dot_q <= dot_sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      mode_q      <= 1'b0;
      pvalid_q    <= 1'b0;
      it_q        <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pvalid_q    <= accept;
      out_valid_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (row_end) begin
              n_q     <= cnt_q + 1'b1;
              cnt_q   <= '0;
              mode_q  <= in_item_i.mode;
              state_q <= ST_DRN;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_DRN:  state_q <= ST_SQI;
        ST_SQI: begin
          it_q    <= '0;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          it_q <= it_q + 1'b1;
          if (it_q == 5'd31) begin
            state_q <= ST_SMUL;
          end
        end
        ST_SMUL: state_q <= ST_DST;
        ST_DST: begin
          active_q <= active_d;
          k_q      <= '0;
          state_q  <= active_d ? ST_DWT : ST_RD;
        end
        ST_DWT: begin
          if (div_rsp.done) begin
            state_q <= ST_RD;
          end
        end
        ST_RD:   state_q <= ST_MUL1;
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= (mode_q && active_q) ? ST_DIVS : ST_OUT;
        ST_DIVS: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_rsp.done) begin
            state_q <= ST_EM1;
          end
        end
        ST_EM1:  state_q <= ST_EM2;
        ST_EM2:  state_q <= ST_EM3;
        ST_EM3:  state_q <= ST_OUT;
        ST_OUT: begin
          out_valid_q <= 1'b1;
          if (k_q + 1'b1 == n_q) begin
            state_q <= ST_LOAD;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          sqp_q <= {32'b0, xm_in} * {32'b0, xm_in};
          dp_q  <= ACC_W'(in_item_i.x_value) * ACC_W'(in_item_i.eta_value);
        end
      end
      ST_SQI: begin
        sq_val_q <= ss_q;
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      ST_SQRT: begin
        sq_val_q <= {sq_val_q[ACC_W-3:0], 2'b00};
        if (sq_r2 >= sq_trial) begin
          sq_rem_q <= sq_r2 - sq_trial;
          root_q   <= {root_q[30:0], 1'b1};
        end else begin
          sq_rem_q <= sq_r2;
          root_q   <= {root_q[30:0], 1'b0};
        end
      end
      ST_SMUL: begin
        s_q    <= {32'b0, w_q} * {31'b0, root_q};
        dmag_q <= dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);
        dneg_q <= dot_q[ACC_W-1];
      end
      ST_DST: begin
        d_q <= '0;
      end
      ST_DWT: begin
        if (div_rsp.done) begin
          d_q <= div_rsp.quo[32] ? 32'hFFFF_FFFF : div_rsp.quo[31:0];
        end
      end
      ST_MUL1: begin
        t1p_q <= {32'b0, vm} * {32'b0, d_q};
        p0_q  <= {32'b0, dmag_q[31:0]} * {32'b0, xm};
      end
      ST_MUL2: begin
        p1_q <= {32'b0, dmag_q[63:32]} * {32'b0, xm};
        t1_q <= t1_rnd[63:32];
        t2_q <= '0;
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          quo_q <= div_rsp.quo;
        end
      end
      ST_EM1: eql_q <= {32'b0, e_val} * {33'b0, quo_q[31:0]};
      ST_EM2: eqh_q <= {32'b0, e_val} * {33'b0, quo_q[63:32]};
      ST_EM3: t2_q  <= (eq_r > {24'b0, TERM_CAP}) ? TERM_CAP : eq_r[CAP_W-1:0];
      ST_OUT: begin
        out_q.y_value  <= ysat;
        out_q.last_out <= (k_q + 1'b1 == n_q);
      end
      default: ;
    endcase
  end

  assign busy        = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_row_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.last_in_row) |=> busy)
    else $error("row end did not raise busy");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.last_out) |-> !busy)
    else $error("busy still high after last result of row");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DWT || state_q == ST_DIVW))
    else $error("divider finished outside a wait state");
`endif

endmodule

[test/group_soft_threshold_prox_test.sv]
module group_soft_threshold_prox_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gstp_pkg::*;

  localparam int RLEN = ROW_LEN_DEF;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  out_item_t            out_item_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  group_soft_threshold_prox dut (.*);

  logic [CFG_W-1:0]        lambda_reg;
  logic [CFG_W-1:0]        weight_reg;
  logic [DATA_W-1:0]       x_row [RLEN];
  logic [DATA_W-1:0]       eta_row [RLEN];
  logic [ACC_W-1:0]        sq_acc;
  logic signed [ACC_W-1:0] dot_acc;
  int                      elem_cnt;
  out_item_t               shrunk_q[$];
  int                      errors;
  int                      sent;
  bit                      gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("group_soft_threshold_prox: mismatch");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] round_scale(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = 128'(a) * 128'(b) + 128'h8000_0000;
    pr = pr >> 32;
    if (pr > 128'(TERM_CAP)) return 64'(TERM_CAP);
    return pr[63:0];
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] with_sign(logic [63:0] m, bit neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic void shrink_accept(in_item_t it);
    logic signed [63:0] xs, es, xj, ej, p, y;
    logic [63:0]        sq, norm, s, lam, d, e, q;
    logic [64:0]        ssum;
    logic signed [65:0] dsum;
    logic [127:0]       num;
    out_item_t          r;
    bit                 active;
    xs = $signed(it.x_value);
    es = $signed(it.eta_value);
    x_row[elem_cnt] = it.x_value;
    eta_row[elem_cnt] = it.eta_value;
    sq = mag(xs) * mag(xs);
    ssum = {1'b0, sq_acc} + {1'b0, sq};
    sq_acc = ssum[64] ? '1 : ssum[63:0];
    p = xs * es;
    dsum = 66'(dot_acc) + 66'(p);
    if (dsum > 66'sh0_7FFF_FFFF_FFFF_FFFF) dot_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (dsum < -66'sh0_8000_0000_0000_0000) dot_acc = 64'sh8000_0000_0000_0000;
    else dot_acc = dsum[63:0];
    elem_cnt++;
    if (!it.last_in_row && elem_cnt < RLEN) return;
    norm = isqrt(sq_acc);
    s = 64'(weight_reg) * norm;
    lam = 64'(lambda_reg) << 16;
    active = s > lam;
    d = 0;
    if (active) begin
      num = 128'(s - lam) << 32;
      num = num / 128'(s);
      d = (num[63:0] > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : num[63:0];
    end
    e = (64'd1 << 32) - d;
    for (int k = 0; k < elem_cnt; k++) begin
      xj = $signed(x_row[k]);
      ej = $signed(eta_row[k]);
      y = 0;
      if (active) begin
        if (!it.mode) begin
          y = with_sign(round_scale(mag(xj), d), xj < 0);
        end else begin
          y = with_sign(round_scale(mag(ej), d), ej < 0);
          num = 128'(mag(dot_acc)) * 128'(mag(xj));
          num = num / 128'(sq_acc);
          q = (num[127:64] != 0) ? '1 : num[63:0];
          y = y + with_sign(round_scale(e, q), (dot_acc < 0) != (xj < 0));
        end
      end
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      r.y_value = y[31:0];
      r.last_out = (k + 1 == elem_cnt);
      shrunk_q.push_back(r);
    end
    sq_acc = 0;
    dot_acc = 0;
    elem_cnt = 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (shrunk_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result y=%h last=%b",
                                   out_item_o.y_value, out_item_o.last_out);
      end else begin
        out_item_t w;
        w = shrunk_q.pop_front();
        if (w.y_value !== out_item_o.y_value || w.last_out !== out_item_o.last_out) begin
          errors++;
          if (errors <= 10) $display("result: expected y=%h last=%b, got y=%h last=%b",
                                     w.y_value, w.last_out,
                                     out_item_o.y_value, out_item_o.last_out);
        end
      end
    end
  end

  task automatic send_elem(logic [31:0] x, logic [31:0] eta, bit last, bit md);
    in_item_t it;
    it.x_value = x;
    it.eta_value = eta;
    it.last_in_row = last;
    it.mode = md;
    start <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (busy);
    shrink_accept(it);
    sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (shrunk_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LAMBDA) lambda_reg = val;
    else weight_reg = val;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4, 5: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_row(int len, bit md);
    for (int j = 0; j < len; j++) begin
      if (j == len - 1) send_elem(rand_val(), rand_val(), len == RLEN ? 1'($urandom) : 1'b1, md);
      else send_elem(rand_val(), rand_val(), 1'b0, 1'($urandom));
    end
  endtask

  task automatic test_directed();
    send_elem(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    send_elem(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_elem(32'h0, 32'h0, 1'b0, 1'b1);
    send_elem(32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_elem(32'h0, 32'h1234_5678, 1'b1, 1'b1);
    send_elem(32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0);
    send_elem(32'h0002_0000, 32'h0000_8000, 1'b0, 1'b0);
    send_elem(32'hFFFF_0000, 32'hFFFD_0000, 1'b1, 1'b1);
    for (int m = 0; m < 2; m++)
      for (int j = 0; j < 4; j++)
        send_elem(32'h8000_0000, 32'h8000_0000, j == 3, 1'(m));
    for (int j = 0; j < 3; j++)
      send_elem(32'h8000_0000, 32'h7FFF_FFFF, j == 2, 1'b1);
  endtask

  task automatic test_row_overflow();
    for (int j = 0; j < RLEN; j++)
      send_elem(32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)), $urandom,
                1'b0, j == RLEN - 1);
  endtask

  task automatic test_register_extremes();
    logic [CFG_W-1:0] lams [7] = '{31'd1, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF, 31'd0,
                                   31'd65536, 31'd32768};
    logic [CFG_W-1:0] wts [7] = '{31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 31'd65536,
                                  31'd0, 31'd196608};
    for (int i = 0; i < 7; i++) begin
      wait_idle();
      write_reg(CFG_LAMBDA, lams[i]);
      write_reg(CFG_WEIGHT, wts[i]);
      send_row($urandom_range(1, 4), 1'b0);
      send_row($urandom_range(1, 4), 1'b1);
    end
    wait_idle();
    write_reg(CFG_LAMBDA, 31'd65536);
    write_reg(CFG_WEIGHT, 31'd65536);
  endtask

  task automatic test_random_rows();
    bit paused;
    paused = 0;
    while (sent < 150) begin
      if ($urandom_range(0, 15) == 0) send_row(RLEN, 1'($urandom));
      else send_row($urandom_range(1, 8), 1'($urandom));
      if (!paused && sent > 110) begin
        wait_idle();
        paused = 1;
        write_reg(CFG_LAMBDA, 31'($urandom_range(1, 1 << 18)));
        write_reg(CFG_WEIGHT, 31'($urandom_range(1, 1 << 18)));
      end
    end
  endtask

  task automatic test_tail_back_to_back();
    gaps_on = 0;
    for (int i = 0; i < 5; i++) send_row($urandom_range(1, 6), 1'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_LAMBDA;
    cfg_wdata_i = '0;
    lambda_reg = CFG_RESET;
    weight_reg = CFG_RESET;
    sq_acc = 0;
    dot_acc = 0;
    elem_cnt = 0;
    errors = 0;
    sent = 0;
    gaps_on = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_row_overflow();
    test_register_extremes();
    test_random_rows();
    test_tail_back_to_back();
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("group_soft_threshold_prox: match");
    end else begin
      $display("group_soft_threshold_prox: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/gstp_pkg.sv
hw/rtl/gstp_div.sv
hw/rtl/group_soft_threshold_prox.sv
test/group_soft_threshold_prox_test.sv
